// ===== hw/rtl/gkem_pkg.sv =====
package gkem_pkg;

    localparam int BUTTON_COUNT   = 12;
    localparam int STICK_DIRS     = 4;
    localparam int EVENT_SLOTS    = BUTTON_COUNT + STICK_DIRS;
    localparam int CODE_W         = 7;
    localparam int MAP_W          = 42;
    localparam int CFG_DATA_W     = MAP_W;
    localparam int CFG_INDEX_W    = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_IDX_W     = $clog2(EVENT_SLOTS);

    localparam logic [CODE_W-1:0] KEY_CODE_LIMIT = 7'd127;

    localparam logic [CODE_W-1:0] ARROW_UP    = 7'd84;
    localparam logic [CODE_W-1:0] ARROW_DOWN  = 7'd85;
    localparam logic [CODE_W-1:0] ARROW_LEFT  = 7'd82;
    localparam logic [CODE_W-1:0] ARROW_RIGHT = 7'd83;

    // stick mask bits
    localparam int STICK_UP    = 0;
    localparam int STICK_DOWN  = 1;
    localparam int STICK_LEFT  = 2;
    localparam int STICK_RIGHT = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MAP_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MAP_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANALOG_ENABLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THRESHOLD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THRESHOLD = 3'd4;

    localparam logic [MAP_W-1:0] KEY_MAP_LOW_RST  = 42'd2840491008059;
    localparam logic [MAP_W-1:0] KEY_MAP_HIGH_RST = 42'd4109187938931;
    localparam logic [7:0]       LOW_THRESH_RST   = 8'd40;
    localparam logic [7:0]       HIGH_THRESH_RST  = 8'd216;

    // one sample after classification: which event slots fire, and their level
    typedef struct packed {
        logic [EVENT_SLOTS-1:0] mask;
        logic [EVENT_SLOTS-1:0] press;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    function automatic logic [CODE_W-1:0] arrow_code(input logic [1:0] dir);
        logic [CODE_W-1:0] code;
        unique case (dir)
            2'd0:    code = ARROW_UP;
            2'd1:    code = ARROW_DOWN;
            2'd2:    code = ARROW_LEFT;
            default: code = ARROW_RIGHT;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] ascii_of(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        case (code) inside
            [7'd1:7'd26]:  ch = 8'({1'b0, code}) + 8'h60;   // a..z
            [7'd27:7'd36]: ch = 8'({1'b0, code}) + 8'd21;   // 0..9
            [7'd37:7'd46]: ch = 8'({1'b0, code}) + 8'd11;   // keypad 0..9
            7'd59:         ch = 8'd27;
            7'd63:         ch = 8'd8;
            7'd64:         ch = 8'd9;
            7'd67, 7'd91:  ch = 8'd13;
            7'd75:         ch = 8'h20;
            7'd86:         ch = 8'h2f;
            7'd87:         ch = 8'h2a;
            7'd88:         ch = 8'h2d;
            7'd89:         ch = 8'h2b;
            7'd103:        ch = 8'h3d;
            default:       ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/gkem_front.sv =====
module gkem_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gkem_pkg::BUTTON_COUNT-1:0]   i_buttons,
    input  logic [7:0]                          i_stick_x,
    input  logic [7:0]                          i_stick_y,
    input  logic [2*gkem_pkg::MAP_W-1:0]        i_key_map,
    input  logic                                i_analog_enable,
    input  logic [7:0]                          i_low_threshold,
    input  logic [7:0]                          i_high_threshold,
    input  gkem_pkg::t_queue_status             i_queue,
    output logic                                o_push,
    output gkem_pkg::t_job                      o_job
);
    import gkem_pkg::*;

    logic [BUTTON_COUNT-1:0] r_prev_buttons;
    logic [STICK_DIRS-1:0]   r_prev_mask;
    logic [BUTTON_COUNT-1:0] w_enabled;
    logic [STICK_DIRS-1:0]   w_mask;
    logic [STICK_DIRS-1:0]   w_diff;
    logic                    w_accept;

    assign o_stall  = i_queue.full;
    assign w_accept = i_valid && !i_queue.full;
    assign o_push   = w_accept;

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            w_enabled[i] = i_key_map[i*CODE_W +: CODE_W] != KEY_CODE_LIMIT;
        end
    end

    // low threshold wins when both hit
    always_comb begin
        w_mask[STICK_UP]    = i_stick_y <= i_low_threshold;
        w_mask[STICK_DOWN]  = !w_mask[STICK_UP] && (i_stick_y >= i_high_threshold);
        w_mask[STICK_LEFT]  = i_stick_x <= i_low_threshold;
        w_mask[STICK_RIGHT] = !w_mask[STICK_LEFT] && (i_stick_x >= i_high_threshold);
        w_diff = i_analog_enable ? (w_mask ^ r_prev_mask) : '0;
    end

    assign o_job.mask  = {w_diff, (i_buttons ^ r_prev_buttons) & w_enabled};
    assign o_job.press = {w_mask, i_buttons};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_mask    <= '0;
        end else if (w_accept) begin
            r_prev_buttons <= i_buttons;
            if (i_analog_enable) begin
                r_prev_mask <= w_mask;
            end
        end
    end

endmodule

// ===== hw/rtl/gkem_queue.sv =====
module gkem_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  gkem_pkg::t_job          i_job,
    input  logic                    i_pop,
    output gkem_pkg::t_job          o_head,
    output gkem_pkg::t_queue_status o_status
);
    import gkem_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.empty  = r_count == '0;
    assign o_status.full   = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/gkem_back.sv =====
module gkem_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gkem_pkg::t_job                  i_head,
    input  gkem_pkg::t_queue_status         i_queue,
    output logic                            o_pop,
    input  logic [2*gkem_pkg::MAP_W-1:0]    i_key_map,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_event_valid,
    output logic [gkem_pkg::CODE_W-1:0]     o_key_code,
    output logic                            o_pressed,
    output logic [7:0]                      o_char_code,
    output logic                            o_last_event
);
    import gkem_pkg::*;

    logic                    r_busy;
    logic [EVENT_SLOTS-1:0]  r_rem;
    logic [EVENT_SLOTS-1:0]  r_press;
    logic                    r_valid;
    logic                    r_event_valid;
    logic [CODE_W-1:0]       r_key_code;
    logic                    r_pressed;
    logic [7:0]              r_char_code;
    logic                    r_last_event;

    logic [EVENT_SLOTS-1:0]  w_src_mask;
    logic [EVENT_SLOTS-1:0]  w_src_press;
    logic                    w_src_valid;
    logic [EVENT_SLOTS-1:0]  w_rest;
    logic [SLOT_IDX_W-1:0]   w_idx;
    logic [CODE_W-1:0]       w_codes [EVENT_SLOTS];
    logic [CODE_W-1:0]       w_code;
    logic                    w_any;
    logic                    w_press;
    logic                    w_advance;
    logic                    w_fire;

    // a partly emitted sample takes priority over the queue head
    assign w_src_mask  = r_busy ? r_rem   : i_head.mask;
    assign w_src_press = r_busy ? r_press : i_head.press;
    assign w_src_valid = r_busy || !i_queue.empty;
    assign w_rest      = w_src_mask & (w_src_mask - 1'b1);
    assign w_any       = w_src_mask != '0;

    always_comb begin
        w_idx = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
            if (w_src_mask[i]) begin
                w_idx = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            w_codes[i] = i_key_map[i*CODE_W +: CODE_W];
        end
        for (int i = 0; i < STICK_DIRS; i++) begin
            w_codes[BUTTON_COUNT+i] = arrow_code(2'(i));
        end
    end

    assign w_code    = w_codes[w_idx];
    assign w_press   = w_src_press[w_idx];
    assign w_advance = !r_valid || !i_stall;
    assign w_fire    = w_advance && w_src_valid;
    assign o_pop     = w_fire && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_busy  <= w_rest != '0;
            r_valid <= 1'b1;
        end else if (w_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rem         <= w_rest;
            r_press       <= w_src_press;
            r_event_valid <= w_any;
            r_key_code    <= w_any ? w_code : '0;
            r_pressed     <= w_any && w_press;
            // stick events carry no character
            r_char_code   <= (w_any && w_press && (w_idx < SLOT_IDX_W'(BUTTON_COUNT)))
                             ? ascii_of(w_code) : 8'd0;
            r_last_event  <= w_rest == '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_valid = r_event_valid;
    assign o_key_code    = r_key_code;
    assign o_pressed     = r_pressed;
    assign o_char_code   = r_char_code;
    assign o_last_event  = r_last_event;

endmodule

// ===== hw/rtl/gamepad_key_event_mapper.sv =====
// Gamepad key event mapper. Each accepted beat is one poll sample; it yields
// one result beat per changed, enabled button (slot order 0..11), then one per
// changed stick direction (up, down, left, right) when analog mapping is on,
// or a single empty marker when nothing changed. The last beat of a sample
// has o_last_event set. Samples are classified on entry and parked in a
// 4-entry queue, so a new sample is taken every cycle while the queue has
// room. The emitter drains one result per cycle while i_stall is low; a
// sample yields max(n, 1) results, n being its event count (at most 16), the
// first registered by the emitter once the sample is in the queue.
// Configuration writes must only happen while no sample is in flight.
module gamepad_key_event_mapper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gkem_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gkem_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gkem_pkg::BUTTON_COUNT-1:0]   i_buttons,
    input  logic [7:0]                          i_stick_x,
    input  logic [7:0]                          i_stick_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_event_valid,
    output logic [gkem_pkg::CODE_W-1:0]         o_key_code,
    output logic                                o_pressed,
    output logic [7:0]                          o_char_code,
    output logic                                o_last_event
);
    import gkem_pkg::*;

    logic [MAP_W-1:0]   r_key_map_low;
    logic [MAP_W-1:0]   r_key_map_high;
    logic               r_analog_enable;
    logic [7:0]         r_low_threshold;
    logic [7:0]         r_high_threshold;

    logic [2*MAP_W-1:0] w_key_map;
    t_job               w_job;
    t_job               w_head;
    t_queue_status      w_queue;
    logic               w_push;
    logic               w_pop;

    assign w_key_map = {r_key_map_high, r_key_map_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_map_low    <= KEY_MAP_LOW_RST;
            r_key_map_high   <= KEY_MAP_HIGH_RST;
            r_analog_enable  <= 1'b1;
            r_low_threshold  <= LOW_THRESH_RST;
            r_high_threshold <= HIGH_THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_MAP_LOW:    r_key_map_low    <= i_cfg_data;
                CFG_KEY_MAP_HIGH:   r_key_map_high   <= i_cfg_data;
                CFG_ANALOG_ENABLE:  r_analog_enable  <= i_cfg_data[0];
                CFG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data[7:0];
                CFG_HIGH_THRESHOLD: r_high_threshold <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    gkem_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_buttons        (i_buttons),
        .i_stick_x        (i_stick_x),
        .i_stick_y        (i_stick_y),
        .i_key_map        (w_key_map),
        .i_analog_enable  (r_analog_enable),
        .i_low_threshold  (r_low_threshold),
        .i_high_threshold (r_high_threshold),
        .i_queue          (w_queue),
        .o_push           (w_push),
        .o_job            (w_job)
    );

    gkem_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_queue)
    );

    gkem_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_queue       (w_queue),
        .o_pop         (w_pop),
        .i_key_map     (w_key_map),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_valid (o_event_valid),
        .o_key_code    (o_key_code),
        .o_pressed     (o_pressed),
        .o_char_code   (o_char_code),
        .o_last_event  (o_last_event)
    );

endmodule

// ===== verif/gamepad_key_event_mapper_tb.sv =====
module gamepad_key_event_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gkem_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int SLOTS_PER_MAP = MAP_W / CODE_W;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              pressed;
        logic [7:0]        ascii;
        logic              last;
    } t_key_event;

    class key_event_tracker;
        logic [MAP_W-1:0]        map_lo;
        logic [MAP_W-1:0]        map_hi;
        logic                    analog_on;
        logic [7:0]              thr_lo;
        logic [7:0]              thr_hi;
        logic [BUTTON_COUNT-1:0] prev_buttons;
        logic [STICK_DIRS-1:0]   prev_dirs;
        logic [7:0]              ascii_rom [0:126];
        t_key_event              pending_events [$];
        int                      errors;

        function new();
            for (int k = 0; k < 127; k++) begin
                if (k >= 1 && k <= 26)
                    ascii_rom[k] = 8'(k + 96);
                else if (k >= 27 && k <= 36)
                    ascii_rom[k] = 8'(k + 21);
                else if (k >= 37 && k <= 46)
                    ascii_rom[k] = 8'(k + 11);
                else
                    ascii_rom[k] = 8'd0;
            end
            ascii_rom[59]  = 8'd27;
            ascii_rom[63]  = 8'd8;
            ascii_rom[64]  = 8'd9;
            ascii_rom[67]  = 8'd13;
            ascii_rom[75]  = " ";
            ascii_rom[86]  = "/";
            ascii_rom[87]  = "*";
            ascii_rom[88]  = "-";
            ascii_rom[89]  = "+";
            ascii_rom[91]  = 8'd13;
            ascii_rom[103] = "=";
            map_lo       = KEY_MAP_LOW_RST;
            map_hi       = KEY_MAP_HIGH_RST;
            analog_on    = 1'b1;
            thr_lo       = LOW_THRESH_RST;
            thr_hi       = HIGH_THRESH_RST;
            prev_buttons = '0;
            prev_dirs    = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KEY_MAP_LOW:    map_lo = data;
                CFG_KEY_MAP_HIGH:   map_hi = data;
                CFG_ANALOG_ENABLE:  analog_on = data[0];
                CFG_LOW_THRESHOLD:  thr_lo = data[7:0];
                CFG_HIGH_THRESHOLD: thr_hi = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        // expected beats for one sample, in emit order
        function void predict_events(logic [BUTTON_COUNT-1:0] buttons, logic [7:0] sx,
                                     logic [7:0] sy);
            t_key_event              ev;
            t_key_event              batch [$];
            logic [BUTTON_COUNT-1:0] flips;
            logic [STICK_DIRS-1:0]   dirs;
            logic [STICK_DIRS-1:0]   dir_flips;
            logic [CODE_W-1:0]       code;
            logic [CODE_W-1:0]       arrow [STICK_DIRS];

            arrow[STICK_UP]    = ARROW_UP;
            arrow[STICK_DOWN]  = ARROW_DOWN;
            arrow[STICK_LEFT]  = ARROW_LEFT;
            arrow[STICK_RIGHT] = ARROW_RIGHT;

            flips = buttons ^ prev_buttons;
            for (int s = 0; s < BUTTON_COUNT; s++) begin
                if (s < SLOTS_PER_MAP)
                    code = map_lo[CODE_W*s +: CODE_W];
                else
                    code = map_hi[CODE_W*(s-SLOTS_PER_MAP) +: CODE_W];
                if (flips[s] && code != KEY_CODE_LIMIT) begin
                    ev         = '0;
                    ev.valid   = 1'b1;
                    ev.code    = code;
                    ev.pressed = buttons[s];
                    ev.ascii   = buttons[s] ? ascii_rom[code] : 8'd0;
                    batch.push_back(ev);
                end
            end
            prev_buttons = buttons;

            // mask is frozen while analog mapping is off
            if (analog_on) begin
                dirs = '0;
                if (sy <= thr_lo)
                    dirs[STICK_UP] = 1'b1;
                else if (sy >= thr_hi)
                    dirs[STICK_DOWN] = 1'b1;
                if (sx <= thr_lo)
                    dirs[STICK_LEFT] = 1'b1;
                else if (sx >= thr_hi)
                    dirs[STICK_RIGHT] = 1'b1;
                dir_flips = dirs ^ prev_dirs;
                for (int d = 0; d < STICK_DIRS; d++) begin
                    if (dir_flips[d]) begin
                        ev         = '0;
                        ev.valid   = 1'b1;
                        ev.code    = arrow[d];
                        ev.pressed = dirs[d];
                        batch.push_back(ev);
                    end
                end
                prev_dirs = dirs;
            end

            if (batch.size() == 0) begin
                ev = '0;
                batch.push_back(ev);
            end
            foreach (batch[i]) begin
                ev      = batch[i];
                ev.last = (i == batch.size() - 1);
                pending_events.push_back(ev);
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_event(t_key_event got);
            t_key_event want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got code %0d",
                         $time, got.code);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_valid", want.valid, got.valid);
            compare_field("key_code", want.code, got.code);
            compare_field("pressed", want.pressed, got.pressed);
            compare_field("char_code", want.ascii, got.ascii);
            compare_field("last_event", want.last, got.last);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [BUTTON_COUNT-1:0] i_buttons;
    logic [7:0]              i_stick_x;
    logic [7:0]              i_stick_y;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_event_valid;
    logic [CODE_W-1:0]       o_key_code;
    logic                    o_pressed;
    logic [7:0]              o_char_code;
    logic                    o_last_event;

    key_event_tracker        tracker = new();
    bit                      quiet = 1'b0;
    bit                      hold_request = 1'b0;
    logic [BUTTON_COUNT-1:0] last_buttons = '0;

    gamepad_key_event_mapper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_buttons     (i_buttons),
        .i_stick_x     (i_stick_x),
        .i_stick_y     (i_stick_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_valid (o_event_valid),
        .o_key_code    (o_key_code),
        .o_pressed     (o_pressed),
        .o_char_code   (o_char_code),
        .o_last_event  (o_last_event)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic offer_sample(input logic [BUTTON_COUNT-1:0] b, input logic [7:0] x,
                                input logic [7:0] y);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_buttons <= b;
        i_stick_x <= x;
        i_stick_y <= y;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.predict_events(b, x, y);
        last_buttons = b;
    endtask

    // wait until every predicted beat has come out
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [MAP_W-1:0] lo, input logic [MAP_W-1:0] hi,
                                input logic an, input logic [7:0] tl, input logic [7:0] th);
        logic [CFG_DATA_W-1:0] vals [CFG_HIGH_THRESHOLD+1];
        vals[CFG_KEY_MAP_LOW]    = lo;
        vals[CFG_KEY_MAP_HIGH]   = hi;
        vals[CFG_ANALOG_ENABLE]  = CFG_DATA_W'(an);
        vals[CFG_LOW_THRESHOLD]  = CFG_DATA_W'(tl);
        vals[CFG_HIGH_THRESHOLD] = CFG_DATA_W'(th);
        for (int r = CFG_KEY_MAP_LOW; r <= CFG_HIGH_THRESHOLD; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_INDEX_W'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            tracker.write_reg(CFG_INDEX_W'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [MAP_W-1:0] random_map();
        logic [MAP_W-1:0] m;
        for (int s = 0; s < SLOTS_PER_MAP; s++)
            m[CODE_W*s +: CODE_W] = ($urandom_range(0, 5) == 0) ? KEY_CODE_LIMIT
                                                                : CODE_W'($urandom_range(0, 126));
        return m;
    endfunction

    // favors the rails, center and values around the current thresholds
    function automatic logic [7:0] pick_stick();
        int v;
        case ($urandom_range(0, 6))
            0:       v = 0;
            1:       v = 255;
            2:       v = 128;
            3:       v = int'(tracker.thr_lo) + int'($urandom_range(0, 2)) - 1;
            4:       v = int'(tracker.thr_hi) + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic random_config();
        logic [7:0] tl;
        logic [7:0] th;
        case ($urandom_range(0, 3))
            0: begin
                tl = 8'($urandom_range(0, 127));
                th = 8'($urandom_range(128, 255));
            end
            1: begin
                tl = 8'($urandom_range(0, 1) * 255);
                th = 8'($urandom_range(0, 1) * 255);
            end
            2: begin
                tl = 8'($urandom_range(128, 255));
                th = 8'($urandom_range(0, 127));
            end
            default: begin
                tl = 8'($urandom_range(0, 255));
                th = 8'($urandom_range(0, 255));
            end
        endcase
        apply_config(random_map(), random_map(), $urandom_range(0, 3) != 0, tl, th);
    endtask

    // mostly a few buttons toggling between polls, like real play
    task automatic random_samples(input int count);
        logic [BUTTON_COUNT-1:0] b;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    b = last_buttons ^ (BUTTON_COUNT'(1) << $urandom_range(0, BUTTON_COUNT-1));
                    if ($urandom_range(0, 1) == 1)
                        b ^= BUTTON_COUNT'(1) << $urandom_range(0, BUTTON_COUNT-1);
                end
                6, 7, 8: b = BUTTON_COUNT'($urandom_range(0, 4095));
                default: b = last_buttons;
            endcase
            offer_sample(b, pick_stick(), pick_stick());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_KEY_MAP_LOW;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_buttons   <= '0;
        i_stick_x   <= 8'd128;
        i_stick_y   <= 8'd128;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mapping: empty marker, all pressed, full 16-beat sample, threshold edges
        offer_sample(12'h000, 8'd128, 8'd128);
        offer_sample(12'hFFF, 8'd0, 8'd0);
        offer_sample(12'h000, 8'd255, 8'd255);
        offer_sample(12'hAAA, 8'd40, 8'd216);
        offer_sample(12'h555, 8'd41, 8'd215);
        offer_sample(12'h555, 8'd41, 8'd215);
        settle();

        // disabled slots, codes 0 and 126, analog off
        apply_config({7'd127, 7'd127, 7'd126, 7'd127, 7'd0, 7'd127}, '0, 1'b0,
                     LOW_THRESH_RST, HIGH_THRESH_RST);
        offer_sample(12'hFFF, 8'd0, 8'd0);
        offer_sample(12'h000, 8'd255, 8'd255);
        offer_sample(12'h0F0, 8'd128, 8'd128);
        settle();

        // every slot disabled; overlapping thresholds, where the low side wins
        apply_config('1, '1, 1'b1, 8'd200, 8'd100);
        offer_sample(12'hFFF, 8'd150, 8'd150);
        offer_sample(12'h000, 8'd250, 8'd50);
        offer_sample(12'h000, 8'd0, 8'd255);
        settle();

        apply_config('1, '1, 1'b1, 8'd0, 8'd0);
        offer_sample(12'h000, 8'd0, 8'd0);
        offer_sample(12'h000, 8'd1, 8'd1);
        offer_sample(12'h000, 8'd255, 8'd0);
        settle();

        apply_config('1, '1, 1'b1, 8'd255, 8'd255);
        offer_sample(12'h000, 8'd255, 8'd255);
        offer_sample(12'h000, 8'd128, 8'd0);
        settle();

        // receiver holds off while samples keep coming, so the queue backs up
        apply_config(KEY_MAP_LOW_RST, KEY_MAP_HIGH_RST, 1'b1, LOW_THRESH_RST, HIGH_THRESH_RST);
        quiet        = 1'b1;
        hold_request = 1'b1;
        random_samples(20);
        quiet = 1'b0;
        settle();

        for (int p = 0; p < 6; p++) begin
            random_config();
            quiet = (p % 3 == 2);
            random_samples(22);
            settle();
        end
        quiet = 1'b0;

        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int         pause;
        t_key_event got;
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            pause = quiet ? 0 : $urandom_range(0, 4);
            if (hold_request) begin
                pause        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (pause > 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.valid   = o_event_valid;
            got.code    = o_key_code;
            got.pressed = o_pressed;
            got.ascii   = o_char_code;
            got.last    = o_last_event;
            tracker.check_event(got);
        end
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
